@@ rtl/core/cpgl_pkg.sv @@
// Shared types and constants for the codepoint pair glyph lookup block.
package cpgl_pkg;

	// Fixed field widths.
	localparam int KEY_W   = 21;
	localparam int IDX_W   = 10;
	localparam int COUNT_W = 11;
	localparam int KIND_W  = 2;

	// Regional indicator range that maps to the blank glyph.
	localparam logic [KEY_W-1:0] RI_LOW  = 21'h1F1E6;
	localparam logic [KEY_W-1:0] RI_HIGH = 21'h1F1FF;

	// Operation codes of an input word.
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// Result kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_PAIR   = 2'd0,
		KIND_SINGLE = 2'd1,
		KIND_BLANK  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic write_entry;
		logic start;
		logic restart;
		logic step;
		logic push_pair;
		logic push_final;
	} cpgl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic done;
		logic hit;
		logic pair_ok;
	} cpgl_status_t;

endpackage

@@ rtl/core/cpgl_ifs.sv @@
// Valid/ready channel interfaces for input and result words.
interface cpgl_in_if import cpgl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [IDX_W-1:0] entry_index;
	logic [KEY_W-1:0] key_first;
	logic [KEY_W-1:0] key_second;

	modport source (output valid, cmd, entry_index, key_first, key_second, input ready);
	modport sink (input valid, cmd, entry_index, key_first, key_second, output ready);
endinterface

interface cpgl_out_if import cpgl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] match_kind;
	logic [IDX_W-1:0]  glyph_index;

	modport source (output valid, match_kind, glyph_index, input ready);
	modport sink (input valid, match_kind, glyph_index, output ready);
endinterface

@@ rtl/core/cpgl_dp.sv @@
// Datapath: key table memory, search bounds, probe compare and result register.
module cpgl_dp import cpgl_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [COUNT_W-1:0]  cfg_wdata,
	input  logic [IDX_W-1:0]    entry_index,
	input  logic [KEY_W-1:0]    key_first,
	input  logic [KEY_W-1:0]    key_second,
	input  cpgl_cmd_t           cmd,
	output cpgl_status_t        status,
	output logic [KIND_W-1:0]   match_kind,
	output logic [IDX_W-1:0]    glyph_index
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [COUNT_W-1:0]   count_q;
	logic [2*KEY_W-1:0]   key_mem_q [TABLE_DEPTH];
	logic [2*KEY_W-1:0]   rdata_q;
	logic [KEY_W-1:0]     key_a_q;
	logic [KEY_W-1:0]     key_b_q;
	logic [KEY_W-1:0]     orig_b_q;
	logic [CW-1:0]        lo_q;
	logic [CW-1:0]        hi_q;
	logic [CW-1:0]        n_q;
	logic [CW-1:0]        mid_q;
	logic                 pend_q;
	logic                 moved_q;
	logic                 eq_q;
	logic [KIND_W-1:0]    kind_q;
	logic [IDX_W-1:0]     glyph_q;

	logic [CW-1:0]        used_n;
	logic                 in_range;
	logic [KEY_W-1:0]     rd_k1;
	logic [KEY_W-1:0]     rd_k2;
	logic                 less;
	logic [CW-1:0]        eff_lo;
	logic [CW-1:0]        eff_hi;
	logic                 eff_moved;
	logic                 eff_eq;
	logic                 open;
	logic [CW-1:0]        mid;
	logic                 is_ri;

	// Searched entry count saturates at the table depth.
	assign used_n = (32'(count_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_q);
	assign in_range = 32'(entry_index) < 32'(TABLE_DEPTH);

	// Fold the probe that just returned into the bounds.
	assign rd_k1 = rdata_q[2*KEY_W-1:KEY_W];
	assign rd_k2 = rdata_q[KEY_W-1:0];
	assign less = (rd_k1 < key_a_q) || ((rd_k1 == key_a_q) && (rd_k2 < key_b_q));

	always_comb begin
		eff_lo    = lo_q;
		eff_hi    = hi_q;
		eff_moved = moved_q;
		eff_eq    = eq_q;
		if (pend_q) begin
			if (less) begin
				eff_lo = mid_q + CW'(1);
			end else begin
				eff_hi    = mid_q;
				eff_moved = 1'b1;
				eff_eq    = (rd_k1 == key_a_q) && (rd_k2 == key_b_q);
			end
		end
	end

	assign open = eff_lo < eff_hi;
	assign mid  = eff_lo + ((eff_hi - eff_lo) >> 1);

	// The lower bound hits when the last entry that moved the upper bound matched.
	assign status.done    = !open;
	assign status.hit     = eff_moved && eff_eq;
	assign status.pair_ok = orig_b_q != '0;

	assign is_ri = (key_a_q >= RI_LOW) && (key_a_q <= RI_HIGH);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Table memory: one write port for loads, one registered read port for probes.
	always_ff @(posedge clk) begin
		if (cmd.write_entry && in_range) begin
			key_mem_q[AW'(entry_index)] <= {key_first, key_second};
		end
		if (cmd.step && open) begin
			rdata_q <= key_mem_q[AW'(mid)];
		end
	end

	// Search control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			moved_q <= 1'b0;
			eq_q    <= 1'b0;
			lo_q    <= '0;
			hi_q    <= '0;
		end else if (cmd.start || cmd.restart) begin
			pend_q  <= 1'b0;
			moved_q <= 1'b0;
			eq_q    <= 1'b0;
			lo_q    <= '0;
			hi_q    <= cmd.start ? used_n : n_q;
		end else if (cmd.step) begin
			pend_q  <= open;
			moved_q <= eff_moved;
			eq_q    <= eff_eq;
			lo_q    <= eff_lo;
			hi_q    <= eff_hi;
		end
	end

	// Keys and probe address.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_a_q  <= key_first;
			key_b_q  <= key_second;
			orig_b_q <= key_second;
			n_q      <= used_n;
		end else if (cmd.restart) begin
			key_b_q <= '0;
		end
		if (cmd.step && open) begin
			mid_q <= mid;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.push_pair) begin
			kind_q  <= KIND_PAIR;
			glyph_q <= IDX_W'(eff_lo);
		end else if (cmd.push_final) begin
			if (status.hit) begin
				kind_q  <= KIND_SINGLE;
				glyph_q <= IDX_W'(eff_lo);
			end else begin
				kind_q  <= is_ri ? KIND_BLANK : KIND_NONE;
				glyph_q <= '0;
			end
		end
	end

	assign match_kind  = kind_q;
	assign glyph_index = glyph_q;

endmodule

@@ rtl/core/cpgl_ctrl.sv @@
// Controller: handshakes and sequencing of the pair search and the single search.
module cpgl_ctrl import cpgl_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_op,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  cpgl_status_t  status,
	output cpgl_cmd_t     cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PAIR,
		S_SINGLE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   can_push;
	logic   pair_win;

	assign in_ready  = state_q == S_IDLE;
	assign accept    = in_valid && in_ready;
	assign can_push  = !out_valid_q || out_ready;
	assign pair_win  = status.hit && status.pair_ok;
	assign out_valid = out_valid_q;

	// Commands to the datapath.
	always_comb begin
		cmd             = '0;
		cmd.write_entry = accept && (in_op == CMD_LOAD);
		cmd.start       = accept && (in_op == CMD_LOOKUP);
		cmd.step        = (state_q == S_PAIR) || (state_q == S_SINGLE);
		cmd.restart     = (state_q == S_PAIR) && status.done && !pair_win;
		cmd.push_pair   = (state_q == S_PAIR) && status.done && pair_win && can_push;
		cmd.push_final  = (state_q == S_SINGLE) && status.done && can_push;
	end

	// State and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push_pair || cmd.push_final) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						state_q <= S_PAIR;
					end
				end
				S_PAIR: begin
					if (cmd.restart) begin
						state_q <= S_SINGLE;
					end else if (cmd.push_pair) begin
						state_q <= S_IDLE;
					end
				end
				S_SINGLE: begin
					if (cmd.push_final) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/codepoint_pair_glyph_lookup.sv @@
// A lookup runs a pair search and, when that fails, a second search on the first key alone;
// each search takes up to ceil(log2(entries+1)) probes, one a cycle through the table read port.
// The second search runs only when the pair search misses or key_second is zero.
// One word is in work at a time; a result waits in the output register.
// Reset clears entry_count and control state; the table contents stay undefined.
module codepoint_pair_glyph_lookup import cpgl_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	cpgl_in_if.sink            lookup,
	cpgl_out_if.source         result
);

	cpgl_cmd_t    cmd;
	cpgl_status_t status;

	// Sequencing.
	cpgl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lookup.valid),
		.in_op     (lookup.cmd),
		.in_ready  (lookup.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Table and search datapath.
	cpgl_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.entry_index (lookup.entry_index),
		.key_first   (lookup.key_first),
		.key_second  (lookup.key_second),
		.cmd         (cmd),
		.status      (status),
		.match_kind  (result.match_kind),
		.glyph_index (result.glyph_index)
	);

endmodule
